### rtl/sfd_pkg.sv
// Shared types and constants of the sum8 frame deframer.
package sfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] LEN_MAX        = 8'd251;
    localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd4;
    localparam logic [BYTE_W-1:0] FAIL_SAT       = 8'hFF;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h40;
    localparam logic [BYTE_W-1:0] ERR_THR_RST    = 8'd40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 1'b0,
        CFG_ERR_THR    = 1'b1
    } t_cfg_idx;

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_CMD  = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_PAY  = 6'b001000,
        PH_CHK  = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_OK         = 3'd1,
        KIND_BAD_SUM    = 3'd2,
        KIND_INCOMPLETE = 3'd3,
        KIND_BAD_LEN    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_length;
        logic              comm_error;
        logic [BYTE_W-1:0] fail_count;
    } t_result;

endpackage

### rtl/sfd_parse.sv
// Frame parser state, running sum and failure bookkeeping for one byte a cycle when stepped.
module sfd_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [sfd_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    input  logic [sfd_pkg::BYTE_W-1:0] i_start_byte,
    input  logic [sfd_pkg::BYTE_W-1:0] i_err_thr,
    output logic                       o_res_valid,
    output sfd_pkg::t_result           o_res
);

    sfd_pkg::t_phase             r_phase, n_phase;
    logic [sfd_pkg::BYTE_W-1:0]  r_cmd, n_cmd;
    logic [sfd_pkg::BYTE_W-1:0]  r_len, n_len;
    logic [sfd_pkg::BYTE_W-1:0]  r_cnt, n_cnt;
    logic [sfd_pkg::BYTE_W-1:0]  r_sum, n_sum;
    logic [sfd_pkg::BYTE_W-1:0]  r_fail, n_fail;
    logic                        r_flag, n_flag;

    logic                        stat;
    sfd_pkg::t_kind              stat_kind;
    logic [sfd_pkg::BYTE_W-1:0]  stat_flen;
    logic                        have_pay;
    logic [sfd_pkg::BYTE_W-1:0]  pay_idx;
    logic [sfd_pkg::BYTE_W-1:0]  fail_inc;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_fail    = r_fail;
        n_flag    = r_flag;
        stat      = 1'b0;
        stat_kind = sfd_pkg::KIND_INCOMPLETE;
        stat_flen = '0;
        have_pay  = 1'b0;
        pay_idx   = '0;
        fail_inc  = (r_fail == sfd_pkg::FAIL_SAT) ? r_fail : r_fail + 8'd1;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_phase)
            sfd_pkg::PH_HUNT: begin
                if (i_byte == i_start_byte) begin
                    n_sum   = i_byte;
                    n_cmd   = '0;
                    n_len   = '0;
                    n_cnt   = '0;
                    n_phase = sfd_pkg::PH_CMD;
                end
            end
            sfd_pkg::PH_CMD: begin
                n_cmd   = i_byte;
                n_sum   = r_sum + i_byte;
                n_phase = sfd_pkg::PH_LEN;
            end
            sfd_pkg::PH_LEN: begin
                n_sum = r_sum + i_byte;
                n_cnt = '0;
                if (i_byte > sfd_pkg::LEN_MAX) begin
                    n_len     = '0;
                    stat      = 1'b1;
                    stat_kind = sfd_pkg::KIND_BAD_LEN;
                    n_phase   = sfd_pkg::PH_DONE;
                end else begin
                    n_len   = i_byte;
                    n_phase = (i_byte != '0) ? sfd_pkg::PH_PAY : sfd_pkg::PH_CHK;
                end
            end
            sfd_pkg::PH_PAY: begin
                n_sum    = r_sum + i_byte;
                have_pay = 1'b1;
                pay_idx  = r_cnt;
                n_cnt    = r_cnt + 8'd1;
                if (n_cnt >= r_len) begin
                    n_phase = sfd_pkg::PH_CHK;
                end
            end
            sfd_pkg::PH_CHK: begin
                stat      = 1'b1;
                stat_kind = (i_byte == r_sum) ? sfd_pkg::KIND_OK : sfd_pkg::KIND_BAD_SUM;
                stat_flen = r_len + sfd_pkg::FRAME_OVERHEAD;
                n_phase   = sfd_pkg::PH_DONE;
            end
            sfd_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase

        // buffer end before any status: report incomplete
        if (i_last && !stat && n_phase != sfd_pkg::PH_DONE) begin
            stat      = 1'b1;
            stat_kind = sfd_pkg::KIND_INCOMPLETE;
            stat_flen = (n_phase == sfd_pkg::PH_PAY || n_phase == sfd_pkg::PH_CHK) ?
                        n_len + sfd_pkg::FRAME_OVERHEAD : '0;
        end

        if (stat) begin
            if (stat_kind == sfd_pkg::KIND_OK) begin
                n_fail = '0;
                n_flag = 1'b0;
            end else if (fail_inc >= i_err_thr) begin
                n_fail = '0;
                n_flag = 1'b1;
            end else begin
                n_fail = fail_inc;
            end
            o_res_valid         = 1'b1;
            o_res.kind          = stat_kind;
            o_res.data          = n_cmd;
            o_res.payload_index = '0;
            o_res.frame_length  = stat_flen;
            o_res.comm_error    = n_flag;
            o_res.fail_count    = n_fail;
        end else if (have_pay && !i_last) begin
            o_res_valid         = 1'b1;
            o_res.kind          = sfd_pkg::KIND_PAYLOAD;
            o_res.data          = i_byte;
            o_res.payload_index = pay_idx;
            o_res.frame_length  = n_len + sfd_pkg::FRAME_OVERHEAD;
            o_res.comm_error    = r_flag;
            o_res.fail_count    = r_fail;
        end

        if (i_last) begin
            n_phase = sfd_pkg::PH_HUNT;
            n_cmd   = '0;
            n_len   = '0;
            n_cnt   = '0;
            n_sum   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfd_pkg::PH_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_fail  <= '0;
            r_flag  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_fail  <= n_fail;
            r_flag  <= n_flag;
        end
    end

endmodule

### rtl/sum8_frame_deframer_unit.sv
// Top level of the sum8 frame deframer: input word register, parser, result register.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | tvalid / tready        | tdata[7:0] rx_byte, tlast buffer_end
//  m_axis   | out | tvalid / tready        | tuser[2:0] kind, tdata see port comment
//  cfg      | in  | i_cfg_we (no wait)     | i_cfg_idx register index, i_cfg_data
//
// One word accepted per cycle unless the output stalls; its result, if any, is held in the result register.
// The parser state advances when the input register holds a word and the result
// register is empty or being taken, so a stalled output holds one word in each register.
// Reset (synchronous, active low) empties both registers, returns the parser to hunting,
// clears the failure counter and flag, and loads start byte 0x40 and threshold 40.
module sum8_frame_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] data, [15:8] payload_index, [23:16] frame_length, [24] comm_error,
    // [32:25] fail_count, [39:33] zero
    output logic [39:0]                   m_axis_tdata,
    output logic [2:0]                    m_axis_tuser,  // [2:0] kind
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data
);

    logic [sfd_pkg::BYTE_W-1:0] r_start_byte;
    logic [sfd_pkg::BYTE_W-1:0] r_err_thr;

    logic                       r_in_valid;
    logic [sfd_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_in_last;

    logic                       r_out_valid;
    sfd_pkg::t_result           r_out;

    logic                       step;
    logic                       res_valid;
    sfd_pkg::t_result           res;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= sfd_pkg::START_BYTE_RST;
            r_err_thr    <= sfd_pkg::ERR_THR_RST;
        end else if (i_cfg_we) begin
            unique case (sfd_pkg::t_cfg_idx'(i_cfg_idx))
                sfd_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_data;
                sfd_pkg::CFG_ERR_THR:    r_err_thr    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    sfd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_start_byte (r_start_byte),
        .i_err_thr    (r_err_thr),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {7'd0, r_out.fail_count, r_out.comm_error, r_out.frame_length,
                            r_out.payload_index, r_out.data};

`ifndef SYNTHESIS
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input register empty but not ready");

    a_pay_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == sfd_pkg::KIND_PAYLOAD) |->
        ({1'b0, m_axis_tdata[15:8]} + {1'b0, sfd_pkg::FRAME_OVERHEAD}
         < {1'b0, m_axis_tdata[23:16]}))
        else $error("payload index beyond frame length");

    a_ok_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == sfd_pkg::KIND_OK) |->
        (m_axis_tdata[32:25] == '0 && !m_axis_tdata[24]))
        else $error("ok status without cleared failure state");

    a_fail_below_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != sfd_pkg::KIND_PAYLOAD
         && m_axis_tuser != sfd_pkg::KIND_OK && r_err_thr != '0) |->
        (m_axis_tdata[32:25] < r_err_thr))
        else $error("failure count at or above threshold");
`endif

endmodule

### sim/sum8_frame_deframer_unit_tb.sv
// Testbench of the sum8 frame deframer: directed and random byte buffers, own parser model, result check.
`timescale 1ns / 1ps

module sum8_frame_deframer_unit_tb;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned PHASE_WORDS  = 300;
    localparam int unsigned HOLD_CYCLES  = 120;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_rx_word;

    typedef enum int unsigned {
        SHAPE_GOOD,
        SHAPE_BAD_SUM,
        SHAPE_CUT,
        SHAPE_BAD_LEN,
        SHAPE_NOISE
    } t_shape;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'd0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              i_cfg_we = 1'b0;
    sfd_pkg::t_cfg_idx i_cfg_idx = sfd_pkg::CFG_START_BYTE;
    logic [7:0]        i_cfg_data = 8'd0;

    sum8_frame_deframer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_rx_word          pending_words[$];
    sfd_pkg::t_result  due_results[$];

    logic [7:0]  cfg_start = sfd_pkg::START_BYTE_RST;
    logic [7:0]  cfg_thr   = sfd_pkg::ERR_THR_RST;

    sfd_pkg::t_phase st_phase = sfd_pkg::PH_HUNT;
    logic [7:0]  st_cmd   = 8'd0;
    logic [7:0]  st_len   = 8'd0;
    logic [7:0]  st_cnt   = 8'd0;
    logic [7:0]  st_sum   = 8'd0;
    logic [7:0]  st_fail  = 8'd0;
    logic        st_flag  = 1'b0;

    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;
    int unsigned burst_left   = 1;
    int unsigned gap_left     = 0;
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 300;
    int unsigned stall_pct    = 0;
    int unsigned rx_cycle     = 0;
    t_rx_word    next_word;
    sfd_pkg::t_result want;

    task automatic flag_mismatch(input string msg);
        if (mismatches < 200)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic sfd_pkg::t_result close_buffer(input sfd_pkg::t_kind k,
                                                      input logic [7:0] flen);
        sfd_pkg::t_result r;
        if (k == sfd_pkg::KIND_OK) begin
            st_fail = 8'd0;
            st_flag = 1'b0;
        end else begin
            if (st_fail != sfd_pkg::FAIL_SAT)
                st_fail = st_fail + 8'd1;
            if (st_fail >= cfg_thr) begin
                st_flag = 1'b1;
                st_fail = 8'd0;
            end
        end
        r.kind          = k;
        r.data          = st_cmd;
        r.payload_index = 8'd0;
        r.frame_length  = flen;
        r.comm_error    = st_flag;
        r.fail_count    = st_fail;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        sfd_pkg::t_result r;
        bit         got;
        bit         have_pay;
        logic [7:0] pay_idx;
        logic [7:0] flen;
        got      = 1'b0;
        have_pay = 1'b0;
        pay_idx  = 8'd0;
        case (st_phase)
            sfd_pkg::PH_HUNT: begin
                if (b == cfg_start) begin
                    st_sum   = b;
                    st_cmd   = 8'd0;
                    st_len   = 8'd0;
                    st_cnt   = 8'd0;
                    st_phase = sfd_pkg::PH_CMD;
                end
            end
            sfd_pkg::PH_CMD: begin
                st_cmd   = b;
                st_sum   = st_sum + b;
                st_phase = sfd_pkg::PH_LEN;
            end
            sfd_pkg::PH_LEN: begin
                st_sum = st_sum + b;
                st_cnt = 8'd0;
                if (b > sfd_pkg::LEN_MAX) begin
                    st_len   = 8'd0;
                    r        = close_buffer(sfd_pkg::KIND_BAD_LEN, 8'd0);
                    got      = 1'b1;
                    st_phase = sfd_pkg::PH_DONE;
                end else begin
                    st_len   = b;
                    st_phase = (b != 8'd0) ? sfd_pkg::PH_PAY : sfd_pkg::PH_CHK;
                end
            end
            sfd_pkg::PH_PAY: begin
                st_sum   = st_sum + b;
                pay_idx  = st_cnt;
                have_pay = 1'b1;
                st_cnt   = st_cnt + 8'd1;
                if (st_cnt >= st_len)
                    st_phase = sfd_pkg::PH_CHK;
            end
            sfd_pkg::PH_CHK: begin
                r        = close_buffer((b == st_sum) ? sfd_pkg::KIND_OK
                                                      : sfd_pkg::KIND_BAD_SUM,
                                        st_len + sfd_pkg::FRAME_OVERHEAD);
                got      = 1'b1;
                st_phase = sfd_pkg::PH_DONE;
            end
            default: ;
        endcase
        if (last) begin
            if (!got && st_phase != sfd_pkg::PH_DONE) begin
                flen = (st_phase == sfd_pkg::PH_PAY || st_phase == sfd_pkg::PH_CHK) ?
                       st_len + sfd_pkg::FRAME_OVERHEAD : 8'd0;
                r    = close_buffer(sfd_pkg::KIND_INCOMPLETE, flen);
                got  = 1'b1;
            end
            st_phase = sfd_pkg::PH_HUNT;
            st_cmd   = 8'd0;
            st_len   = 8'd0;
            st_cnt   = 8'd0;
            st_sum   = 8'd0;
        end else if (have_pay) begin
            r.kind          = sfd_pkg::KIND_PAYLOAD;
            r.data          = b;
            r.payload_index = pay_idx;
            r.frame_length  = st_len + sfd_pkg::FRAME_OVERHEAD;
            r.comm_error    = st_flag;
            r.fail_count    = st_fail;
            got             = 1'b1;
        end
        if (got)
            due_results.push_back(r);
    endtask

    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == cfg_start);
        return b;
    endfunction

    // keep: frame bytes left when the buffer is cut short
    task automatic add_buffer(input t_shape shape, input logic [7:0] cmd,
                              input int unsigned plen, input int unsigned n_noise,
                              input int unsigned n_trail, input int unsigned keep);
        logic [7:0]  bytes_q[$];
        logic [7:0]  frame_q[$];
        logic [7:0]  sum;
        t_rx_word    w;
        int unsigned i;
        for (i = 0; i < n_noise; i++)
            bytes_q.push_back(other_byte());
        if (shape == SHAPE_NOISE) begin
            if (n_noise == 0)
                bytes_q.push_back(other_byte());
        end else begin
            frame_q.push_back(cfg_start);
            frame_q.push_back(cmd);
            frame_q.push_back(8'(plen));
            if (shape != SHAPE_BAD_LEN) begin
                for (i = 0; i < plen; i++)
                    frame_q.push_back(8'($urandom_range(255)));
                sum = 8'd0;
                foreach (frame_q[j])
                    sum = sum + frame_q[j];
                if (shape == SHAPE_BAD_SUM)
                    sum = sum + 8'($urandom_range(1, 255));
                frame_q.push_back(sum);
            end
            if (shape == SHAPE_CUT) begin
                while (frame_q.size() > keep)
                    void'(frame_q.pop_back());
            end
            foreach (frame_q[j])
                bytes_q.push_back(frame_q[j]);
        end
        if (shape != SHAPE_CUT) begin
            for (i = 0; i < n_trail; i++)
                bytes_q.push_back(8'($urandom_range(255)));
        end
        foreach (bytes_q[j]) begin
            w.rx_byte    = bytes_q[j];
            w.buffer_end = (j == bytes_q.size() - 1);
            pending_words.push_back(w);
        end
    endtask

    task automatic fill_random(input int unsigned n_words);
        int unsigned pick;
        int unsigned plen;
        int unsigned n_noise;
        int unsigned n_trail;
        t_shape      shape;
        while (pending_words.size() < n_words) begin
            pick  = $urandom_range(99);
            shape = (pick < 55) ? SHAPE_GOOD :
                    (pick < 70) ? SHAPE_BAD_SUM :
                    (pick < 85) ? SHAPE_CUT :
                    (pick < 92) ? SHAPE_BAD_LEN : SHAPE_NOISE;
            pick = $urandom_range(199);
            if (pick == 0)
                plen = sfd_pkg::LEN_MAX;
            else if (pick < 20)
                plen = $urandom_range(13, 120);
            else
                plen = $urandom_range(0, 12);
            if (shape == SHAPE_BAD_LEN)
                plen = $urandom_range(sfd_pkg::LEN_MAX + 1, 255);
            n_noise = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
            n_trail = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
            add_buffer(shape, 8'($urandom_range(255)), plen, n_noise, n_trail,
                       $urandom_range(1, plen + 3));
        end
    endtask

    task automatic write_reg(input sfd_pkg::t_cfg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == sfd_pkg::CFG_START_BYTE)
            cfg_start = val;
        else
            cfg_thr = val;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || due_results.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // sender: bursts and gaps, word held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    next_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.rx_byte;
                    s_axis_tlast  <= next_word.buffer_end;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each taken word, stall on its own pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("result with none due: kind %0d data %02h",
                                            m_axis_tuser, m_axis_tdata[7:0]));
                end else begin
                    want = due_results.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.data ||
                        m_axis_tdata[15:8] !== want.payload_index ||
                        m_axis_tdata[23:16] !== want.frame_length ||
                        m_axis_tdata[24] !== want.comm_error ||
                        m_axis_tdata[32:25] !== want.fail_count ||
                        m_axis_tdata[39:33] !== 7'd0)
                        flag_mismatch({
                            $sformatf("got kind %0d data %02h idx %0d len %0d",
                                      m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                                      m_axis_tdata[23:16]),
                            $sformatf(" err %0b fails %0d pad %0h,",
                                      m_axis_tdata[24], m_axis_tdata[32:25],
                                      m_axis_tdata[39:33]),
                            $sformatf(" want kind %0d data %02h idx %0d len %0d",
                                      want.kind, want.data, want.payload_index,
                                      want.frame_length),
                            $sformatf(" err %0b fails %0d",
                                      want.comm_error, want.fail_count)});
                end
            end
            if (rx_cycle % 150 == 0) begin
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            rx_cycle++;
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (results_seen >= next_hold_at) begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + 700;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("sum8_frame_deframer_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_buffer(SHAPE_GOOD, 8'hFF, 0, 0, 0, 0);
        add_buffer(SHAPE_GOOD, 8'h00, 2, 0, 0, 0);
        add_buffer(SHAPE_BAD_SUM, 8'h5A, 1, 0, 0, 0);
        add_buffer(SHAPE_BAD_LEN, 8'h33, 252, 0, 1, 0);
        add_buffer(SHAPE_BAD_LEN, 8'hA5, 255, 0, 0, 0);
        add_buffer(SHAPE_NOISE, 8'h00, 0, 2, 0, 0);
        add_buffer(SHAPE_CUT, 8'hC3, 3, 0, 0, 3);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                case (ph)
                    1: begin
                        write_reg(sfd_pkg::CFG_START_BYTE, 8'h00);
                        write_reg(sfd_pkg::CFG_ERR_THR, 8'd1);
                    end
                    2: begin
                        write_reg(sfd_pkg::CFG_START_BYTE, 8'hFF);
                        write_reg(sfd_pkg::CFG_ERR_THR, 8'd255);
                    end
                    3: begin
                        write_reg(sfd_pkg::CFG_START_BYTE, 8'($urandom_range(255)));
                        write_reg(sfd_pkg::CFG_ERR_THR, 8'd0);
                    end
                    4: begin
                        write_reg(sfd_pkg::CFG_START_BYTE, sfd_pkg::START_BYTE_RST);
                        write_reg(sfd_pkg::CFG_ERR_THR, 8'd3);
                    end
                    default: begin
                        write_reg(sfd_pkg::CFG_START_BYTE, 8'($urandom_range(255)));
                        write_reg(sfd_pkg::CFG_ERR_THR, 8'($urandom_range(1, 8)));
                    end
                endcase
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
                @(negedge i_clk);
            end
            fill_random(PHASE_WORDS);
            wait_drained();
        end

        if (mismatches == 0)
            $display("sum8_frame_deframer_unit test passed");
        else
            $display("sum8_frame_deframer_unit test failed");
        $finish;
    end

endmodule
